FILE: hw/rtl/prf_pkg.sv
// Shared types and constants for the planar rectangle fill unit.
package prf_pkg;

	localparam int BYTES_PER_ROW = 80;
	localparam int PLANE_COUNT   = 4;
	localparam int ROW_COUNT     = 480;

	localparam int XW    = 10;
	localparam int YW    = 9;
	localparam int COLW  = 7;
	localparam int CLRW  = 4;
	localparam int PLW   = 2;
	localparam int ADRW  = 16;

	localparam logic [XW-1:0] X_MAX      = XW'(BYTES_PER_ROW * 8 - 1);
	localparam logic [YW-1:0] Y_MAX      = YW'(ROW_COUNT - 1);
	localparam logic [PLW-1:0] LAST_PLANE = PLW'(PLANE_COUNT - 1);
	localparam logic [7:0] MASK_FULL     = 8'hFF;
	localparam logic [7:0] FILL_SET      = 8'hFF;
	localparam logic [7:0] FILL_CLEAR    = 8'h00;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [COLW-1:0] left_col;
		logic [COLW-1:0] right_col;
		logic [7:0]      left_mask;
		logic [7:0]      right_mask;
		logic [YW-1:0]   top_row;
		logic [YW-1:0]   bottom_row;
		logic [CLRW-1:0] color;
	} setup_t;

	typedef struct packed {
		logic [PLW-1:0]  plane;
		logic [ADRW-1:0] addr;
		logic [7:0]      mask;
		logic [7:0]      fill;
		logic            last;
	} result_t;

endpackage

FILE: hw/rtl/prf_setup.sv
// Start request decode: clamps and orders the corners, derives edge columns and masks.
module prf_setup import prf_pkg::*; (
	input  logic [XW-1:0]   corner_x1,
	input  logic [YW-1:0]   corner_y1,
	input  logic [XW-1:0]   corner_x2,
	input  logic [YW-1:0]   corner_y2,
	input  logic [CLRW-1:0] fill_color,
	output setup_t          setup
);

	logic [XW-1:0] xa, xb, lft, rgt;
	logic [YW-1:0] ya, yb;

	always_comb begin
		xa  = (corner_x1 > X_MAX) ? X_MAX : corner_x1;
		xb  = (corner_x2 > X_MAX) ? X_MAX : corner_x2;
		ya  = (corner_y1 > Y_MAX) ? Y_MAX : corner_y1;
		yb  = (corner_y2 > Y_MAX) ? Y_MAX : corner_y2;
		lft = (xa < xb) ? xa : xb;
		rgt = (xa > xb) ? xa : xb;

		setup.top_row    = (ya < yb) ? ya : yb;
		setup.bottom_row = (ya > yb) ? ya : yb;
		setup.left_col   = lft[XW-1:3];
		setup.right_col  = rgt[XW-1:3];
		setup.left_mask  = MASK_FULL >> lft[2:0];
		setup.right_mask = MASK_FULL << (3'd7 - rgt[2:0]);
		setup.color      = fill_color;
	end

endmodule

FILE: hw/rtl/prf_walk.sv
// Walk state of the fill: steps through planes, rows and byte columns, one write per step.
module prf_walk import prf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    step,
	input  setup_t  setup,
	output logic    res_valid,
	output result_t res
);

	logic            busy_q;
	setup_t          run_q;
	logic [PLW-1:0]  plane_q;
	logic [YW-1:0]   row_q;
	logic [COLW-1:0] col_q;

	logic at_left, at_right;

	always_comb begin
		at_left  = (col_q == run_q.left_col);
		at_right = (col_q == run_q.right_col);
		res_valid = step && busy_q;

		if (at_left && at_right) begin
			res.mask = run_q.left_mask & run_q.right_mask;
		end else if (at_left) begin
			res.mask = run_q.left_mask;
		end else if (at_right) begin
			res.mask = run_q.right_mask;
		end else begin
			res.mask = MASK_FULL;
		end

		res.plane = plane_q;
		res.addr  = ADRW'(32'(row_q) * BYTES_PER_ROW) + ADRW'(col_q);
		res.fill  = run_q.color[plane_q] ? FILL_SET : FILL_CLEAR;
		res.last  = (plane_q >= LAST_PLANE) && (row_q >= run_q.bottom_row) && at_right;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			run_q   <= '0;
			plane_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			run_q   <= setup;
			plane_q <= '0;
			row_q   <= setup.top_row;
			col_q   <= setup.left_col;
		end else if (res_valid) begin
			if (res.last) begin
				busy_q <= 1'b0;
			end else if (col_q < run_q.right_col) begin
				col_q <= col_q + 1'b1;
			end else begin
				col_q <= run_q.left_col;
				if (row_q < run_q.bottom_row) begin
					row_q <= row_q + 1'b1;
				end else begin
					row_q   <= run_q.top_row;
					plane_q <= plane_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/planar_rectangle_fill_unit.sv
// Top level of the planar rectangle fill unit: input register, walk logic and result register.
// The unit takes one request per clock cycle while the output is not stalled. A start request
// loads the rectangle and colour and gives no result; each following step request gives one
// video-memory write, planes outermost, then rows, then byte columns, with the final write
// marked by tlast. A step while idle gives nothing, and a start at any time abandons the
// current fill. A request waits in the input register until the result register can take its
// write, which is then registered there and presented; the walk state advances once per step
// taken, which sets the sustained rate of one write per clock while the output is drained.
module planar_rectangle_fill_unit import prf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// corner_x1[9:0], corner_y1[18:10], corner_x2[28:19], corner_y2[37:29],
	// fill_color[41:38], zero [47:42]
	input  logic [47:0] s_axis_tdata,
	// cmd[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// plane_index[1:0], byte_address[17:2], bit_mask[25:18], fill_byte[33:26], zero [39:34]
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [41:0] data_s1;

	logic    advance;
	logic    start, step;
	setup_t  setup;
	logic    res_valid;
	result_t res;

	logic    out_valid_q;
	result_t out_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign start         = advance && (cmd_s1 == CMD_START);
	assign step          = advance && (cmd_s1 == CMD_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= cmd_t'(s_axis_tuser);
			data_s1 <= s_axis_tdata[41:0];
		end
	end

	prf_setup u_setup (
		.corner_x1  (data_s1[9:0]),
		.corner_y1  (data_s1[18:10]),
		.corner_x2  (data_s1[28:19]),
		.corner_y2  (data_s1[37:29]),
		.fill_color (data_s1[41:38]),
		.setup      (setup)
	);

	prf_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.step      (step),
		.setup     (setup),
		.res_valid (res_valid),
		.res       (res)
	);

	// Each advance loads its write, if any, into the result register, else empties it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_q.fill, out_q.mask, out_q.addr, out_q.plane};
	assign m_axis_tlast  = out_q.last;

endmodule
